// ===== hw/rtl/spd_pkg.sv =====
// Shared types and constants of the serial packet deframer.
package spd_pkg;

    localparam int BUF_DEPTH = 64;
    localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    localparam int BYTE_W = 8;
    localparam int TYPE_W = 16;
    localparam int IDX_W  = 6;
    localparam int LEN_W  = 7;
    localparam int CIDX_W = 2;

    localparam logic [BYTE_W-1:0] HEADER_RST = 8'hAA;
    localparam logic [BYTE_W-1:0] FOOTER_RST = 8'h55;
    localparam logic [LEN_W-1:0]  MAXLEN_RST = 7'd64;

    typedef enum logic [CIDX_W-1:0] {
        CFG_HEADER = 2'd0,
        CFG_FOOTER = 2'd1,
        CFG_MAXLEN = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_buf_wr;

    typedef struct packed {
        logic              start;
        logic [LEN_W-1:0]  length;
        logic [TYPE_W-1:0] ptype;
    } t_burst_req;

    typedef struct packed {
        logic [TYPE_W-1:0] ptype;
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  idx;
        logic [LEN_W-1:0]  length;
        logic              has;
        logic              last;
    } t_item;

endpackage

// ===== hw/rtl/spd_buf.sv =====
// Payload buffer: one write port, one read port, registered read data.
module spd_buf
    import spd_pkg::*;
(
    input  logic              i_clk,
    input  t_buf_wr           i_wr,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] r_mem [BUF_DEPTH];
    logic [BYTE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

// ===== hw/rtl/spd_parse.sv =====
// Frame parser: header hunt, length check, type capture, payload write, footer check.
module spd_parse
    import spd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0] i_cfg_wdata,
    input  logic              i_acc,
    input  logic [BYTE_W-1:0] i_byte,
    output t_buf_wr           o_wr,
    output t_burst_req        o_req
);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_TYPE_HI = 3'd2,
        PH_TYPE_LO = 3'd3,
        PH_DATA    = 3'd4,
        PH_FOOTER  = 3'd5
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_header, r_footer;
    logic [LEN_W-1:0]  r_maxlen;
    logic [LEN_W-1:0]  r_explen, n_explen;
    logic [LEN_W-1:0]  r_fill, n_fill;
    logic [TYPE_W-1:0] r_type, n_type;
    logic [LEN_W-1:0]  fill_inc;
    logic              len_bad;

    assign fill_inc = r_fill + LEN_W'(1);
    assign len_bad  = (i_byte > {1'b0, r_maxlen}) || (i_byte > BYTE_W'(BUF_DEPTH));

    always_comb begin
        n_phase      = r_phase;
        n_explen     = r_explen;
        n_fill       = r_fill;
        n_type       = r_type;
        o_wr.en      = 1'b0;
        o_wr.addr    = r_fill[ADDR_W-1:0];
        o_wr.data    = i_byte;
        o_req.start  = 1'b0;
        o_req.length = r_explen;
        o_req.ptype  = r_type;
        if (i_acc) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (i_byte == r_header) begin
                        n_phase = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    if (len_bad) begin
                        n_phase = PH_HEADER;
                    end else begin
                        n_explen = i_byte[LEN_W-1:0];
                        n_fill   = '0;
                        n_phase  = PH_TYPE_HI;
                    end
                end
                PH_TYPE_HI: begin
                    n_type  = {{(TYPE_W-BYTE_W){1'b0}}, i_byte};
                    n_phase = PH_TYPE_LO;
                end
                PH_TYPE_LO: begin
                    n_type  = {r_type[BYTE_W-1:0], i_byte};
                    n_phase = (r_explen != '0) ? PH_DATA : PH_FOOTER;
                end
                PH_DATA: begin
                    o_wr.en = (r_fill < LEN_W'(BUF_DEPTH));
                    n_fill  = fill_inc;
                    if (fill_inc >= r_explen) begin
                        n_phase = PH_FOOTER;
                    end
                end
                PH_FOOTER: begin
                    o_req.start = (i_byte == r_footer);
                    n_phase     = PH_HEADER;
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_explen <= '0;
            r_fill   <= '0;
            r_type   <= '0;
            r_header <= HEADER_RST;
            r_footer <= FOOTER_RST;
            r_maxlen <= MAXLEN_RST;
        end else begin
            r_phase  <= n_phase;
            r_explen <= n_explen;
            r_fill   <= n_fill;
            r_type   <= n_type;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_HEADER) begin
                    r_header <= i_cfg_wdata;
                end else if (i_cfg_idx == CFG_FOOTER) begin
                    r_footer <= i_cfg_wdata;
                end else if (i_cfg_idx == CFG_MAXLEN) begin
                    r_maxlen <= i_cfg_wdata[LEN_W-1:0];
                end
            end
        end
    end

endmodule

// ===== hw/rtl/spd_emit.sv =====
// Burst reader: walks the buffer and feeds an output register with a skid entry.
module spd_emit
    import spd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_burst_req        i_req,
    output logic              o_rd_en,
    output logic [ADDR_W-1:0] o_rd_addr,
    input  logic [BYTE_W-1:0] i_rd_data,
    output logic              o_busy,
    output logic              o_valid,
    input  logic              i_stall,
    output t_item             o_item
);

    logic              r_active, n_active;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [LEN_W-1:0]  r_len;
    logic [TYPE_W-1:0] r_type;
    logic              r_pend, r_out_vld, n_out_vld, r_skid_vld, n_skid_vld;
    t_item             r_pend_meta, n_pend_meta;
    t_item             r_out, n_out, r_skid, n_skid;
    t_item             arrive;
    logic              pop, issue, is_last, has;
    logic [1:0]        occ;

    assign pop     = r_out_vld && !i_stall;
    assign occ     = 2'(r_out_vld) + 2'(r_skid_vld) + 2'(r_pend) - 2'(pop);
    assign issue   = r_active && (occ < 2'd2);
    assign has     = (r_len != '0);
    assign is_last = !has || ({1'b0, r_idx} + LEN_W'(1) == r_len);

    assign o_rd_en   = issue && has;
    assign o_rd_addr = r_idx[ADDR_W-1:0];

    // Meta of the read in flight; the data lane is filled on arrival.
    always_comb begin
        n_pend_meta        = r_pend_meta;
        n_pend_meta.ptype  = r_type;
        n_pend_meta.data   = '0;
        n_pend_meta.idx    = r_idx;
        n_pend_meta.length = r_len;
        n_pend_meta.has    = has;
        n_pend_meta.last   = is_last;
    end

    always_comb begin
        arrive      = r_pend_meta;
        arrive.data = r_pend_meta.has ? i_rd_data : '0;
    end

    always_comb begin
        n_active   = r_active;
        n_idx      = r_idx;
        n_out      = r_out;
        n_skid     = r_skid;
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        if (i_req.start) begin
            n_active = 1'b1;
            n_idx    = '0;
        end else if (issue) begin
            n_idx = r_idx + IDX_W'(1);
            if (is_last) begin
                n_active = 1'b0;
            end
        end
        if (r_skid_vld) begin
            if (pop) begin
                n_out = r_skid;
                if (r_pend) begin
                    n_skid = arrive;
                end else begin
                    n_skid_vld = 1'b0;
                end
            end
        end else if (r_pend) begin
            if (!r_out_vld || pop) begin
                n_out     = arrive;
                n_out_vld = 1'b1;
            end else begin
                n_skid     = arrive;
                n_skid_vld = 1'b1;
            end
        end else if (pop) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_pend     <= 1'b0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_active   <= n_active;
            r_pend     <= issue;
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
            r_idx      <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_len  <= i_req.length;
            r_type <= i_req.ptype;
        end
        r_pend_meta <= n_pend_meta;
        r_out       <= n_out;
        r_skid      <= n_skid;
    end

    assign o_busy  = r_active || r_pend || r_out_vld || r_skid_vld;
    assign o_valid = r_out_vld;
    assign o_item  = r_out;

endmodule

// ===== hw/rtl/serial_packet_deframer.sv =====
// Top level of the serial packet deframer: parser, payload buffer and burst reader.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------------
//   in      | input     | i_in_valid / o_in_stall    | i_rx_byte
//   out     | output    | o_out_valid / i_out_stall  | o_packet_type, o_payload_byte,
//           |           |                            | o_byte_index, o_payload_length,
//           |           |                            | o_has_payload, o_last
//   cfg     | input     | i_cfg_we                   | i_cfg_idx, i_cfg_wdata
//
// Cycles: while parsing, one received word is taken every cycle. A good packet of
//   N payload bytes gives N output words (one word for an empty packet), read from
//   the single buffer read port at one word per cycle while the output does not
//   stall; the input stalls from the cycle after the footer until the last word is taken.
// Reset: synchronous, active low; clears the parser and burst control and restores
//   the configuration defaults. The payload buffer is not cleared.
// Stalls: an output stall holds the output word; a skid entry keeps one read in
//   flight so the burst resumes without a bubble.
module serial_packet_deframer
    import spd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [TYPE_W-1:0] o_packet_type,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic [IDX_W-1:0]  o_byte_index,
    output logic [LEN_W-1:0]  o_payload_length,
    output logic              o_has_payload,
    output logic              o_last
);

    logic              in_acc;
    logic              busy;
    t_buf_wr           buf_wr;
    t_burst_req        burst_req;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;
    t_item             item;

    // Hold the input off while a burst is being read out of the buffer; this
    // also keeps the parser from overwriting entries still to be read.
    assign o_in_stall = busy;
    assign in_acc     = i_in_valid && !busy;

    spd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_acc       (in_acc),
        .i_byte      (i_rx_byte),
        .o_wr        (buf_wr),
        .o_req       (burst_req)
    );

    spd_buf u_buf (
        .i_clk     (i_clk),
        .i_wr      (buf_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    spd_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (burst_req),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_busy    (busy),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_item    (item)
    );

    assign o_packet_type    = item.ptype;
    assign o_payload_byte   = item.data;
    assign o_byte_index     = item.idx;
    assign o_payload_length = item.length;
    assign o_has_payload    = item.has;
    assign o_last           = item.last;

    // Output words only appear while the input is held off.
    a_out_implies_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("output word while input not stalled");

    // Taking the last word empties the burst path.
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last) |=> (!o_out_valid && !o_in_stall))
        else $error("burst path not empty after last word");

    // A burst only starts right after an accepted input word (the footer).
    a_burst_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && !o_in_stall))
        else $error("burst started without a footer word");

    // An empty packet is always a single word marked last.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_payload) |-> (o_last && o_payload_length == '0))
        else $error("empty packet word not marked last");

endmodule
